### sv/assert_macros.svh
// Assertion macros used by the top level of the ordered list store.
// Clocked on clk, disabled while rst_n is low; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define OLSD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("olsd assertion failed");

`define OLSD_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("olsd assertion failed");

`define OLSD_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("olsd assertion failed");

`else

`define OLSD_ASSERT_ALWAYS(lbl, prop)
`define OLSD_ASSERT_IMP(lbl, cond, prop)
`define OLSD_ASSERT_NXT(lbl, cond, prop)

`endif

`endif

### sv/olsd_pkg.sv
// Package for the ordered list store: widths, command and status codes, cell ops.
// No dependencies.
package olsd_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SIZE   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

### sv/olsd_cell.sv
// One storage cell of the list row: holds one entry, compares it, shifts to neighbors.
// Depends on olsd_pkg.
module olsd_cell (
  input  logic                               clk,
  input  olsd_pkg::cell_ctl_t                ctl,
  input  logic signed [olsd_pkg::DATA_W-1:0] value,
  input  logic signed [olsd_pkg::DATA_W-1:0] left_data,
  input  logic signed [olsd_pkg::DATA_W-1:0] right_data,
  output logic signed [olsd_pkg::DATA_W-1:0] entry,
  output logic                               eq
);
  import olsd_pkg::*;

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  always_comb begin
    unique case (ctl.op)
      CELL_LOAD:  entry_nxt = value;
      CELL_LEFT:  entry_nxt = left_data;
      CELL_RIGHT: entry_nxt = right_data;
      default:    entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign eq    = (entry_r == value);

endmodule

### sv/olsd_first_hit.sv
// Marks every cell at or behind the first matching cell (m | -m over the match vector).
// Depends on olsd_pkg for the default depth.
module olsd_first_hit #(
  parameter int DEPTH = olsd_pkg::DEPTH_DEF
) (
  input  logic [DEPTH-1:0] match,
  output logic [DEPTH-1:0] from_hit,
  output logic             found
);

  assign from_hit = match | (~match + {{(DEPTH-1){1'b0}}, 1'b1});
  assign found    = |match;

endmodule

### sv/ordered_list_store_delete_by_value.sv
// Top level of the ordered list store: row of cells, counter, command decode, result register.
// Depends on olsd_pkg, olsd_cell, olsd_first_hit and assert_macros.svh.
//
// A command is taken at any clock edge with start high; busy is always low, so one
// command per cycle is sustained. Its result appears on out_status/out_count with
// out_valid in the cycle after the transfer and cannot be stalled. The cycle is set by
// the cell row: every cell compares its entry with in_value in parallel, a single
// DEPTH-wide add finds the first hit, and all moving cells change in the same edge. The entry
// store needs no clearing pass after reset.
`include "assert_macros.svh"

module ordered_list_store_delete_by_value #(
  parameter int DEPTH = olsd_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [olsd_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [olsd_pkg::DATA_W-1:0]   in_value,
  input  logic                                 cfg_we,
  input  logic                                 cfg_order_mode,
  output logic                                 out_valid,
  output logic [olsd_pkg::STATUS_W-1:0]        out_status,
  output logic [olsd_pkg::COUNT_W-1:0]         out_count
);
  import olsd_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                     mode_r;
  logic [CNT_W-1:0]         used_r;
  logic [CNT_W-1:0]         used_nxt;
  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [STATUS_W-1:0]      status_nxt;
  logic [COUNT_W-1:0]       out_count_r;

  logic                     accept;
  logic                     full;
  logic                     found;
  cmd_t                     cmd;
  logic [DEPTH-1:0]         eq_vec;
  logic [DEPTH-1:0]         match;
  logic [DEPTH-1:0]         from_hit;
  logic signed [DATA_W-1:0] ent [DEPTH];
  cell_ctl_t                ctl [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(in_cmd);
  assign full   = (used_r == FULL_CNT);

  olsd_first_hit #(.DEPTH(DEPTH)) u_hit (
    .match    (match),
    .from_hit (from_hit),
    .found    (found)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid
      assign left_d = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = ent[i];
    end else begin : g_inner
      assign right_d = ent[i+1];
    end

    assign match[i] = eq_vec[i] && (CNT_W'(i) < used_r);

    always_comb begin
      ctl[i].op = CELL_HOLD;
      if (accept) begin
        unique case (cmd)
          CMD_ADD: begin
            if (!full) begin
              if (!mode_r) begin
                ctl[i].op = (i == 0) ? CELL_LOAD : CELL_LEFT;
              end else if (used_r == CNT_W'(i)) begin
                ctl[i].op = CELL_LOAD;
              end
            end
          end
          CMD_REMOVE: begin
            if (from_hit[i]) begin
              ctl[i].op = CELL_RIGHT;
            end
          end
          default: ctl[i].op = CELL_HOLD;
        endcase
      end
    end

    olsd_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .value      (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .entry      (ent[i]),
      .eq         (eq_vec[i])
    );
  end

  always_comb begin
    used_nxt   = used_r;
    status_nxt = ST_OK;
    unique case (cmd)
      CMD_ADD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          used_nxt = used_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (used_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          used_nxt = used_r - 1'b1;
        end
      end
      CMD_CLEAR: used_nxt = '0;
      default:   used_nxt = used_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_order_mode;
      end
      out_valid_r <= accept;
      if (accept) begin
        used_r <= used_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_count_r  <= COUNT_W'(used_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  `OLSD_ASSERT_ALWAYS(a_used_bound, used_r <= FULL_CNT)
  `OLSD_ASSERT_NXT(a_result_follows, accept, out_valid)
  `OLSD_ASSERT_NXT(a_clear_empties, accept && cmd == CMD_CLEAR, used_r == '0 && out_count == '0)
  `OLSD_ASSERT_IMP(a_full_count, out_valid && out_status == ST_FULL, used_r == FULL_CNT)

endmodule
